>>> rtl/core/dmwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwt_pkg
// Shared constants for the direct-mapped write-through cache: field widths,
// operation codes and default geometry.
// ----------------------------------------------------------------------------
package dmwt_pkg;

    // Fixed widths of the channel fields.
    localparam int OP_BITS    = 2;
    localparam int ADDR_BITS  = 10;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 32;

    // Default geometry. Block size, line count and memory size are powers of two.
    localparam int DEF_WORDS_PER_BLOCK = 4;
    localparam int DEF_LINE_COUNT      = 16;
    localparam int DEF_MEMORY_WORDS    = 1024;
    localparam int DEF_WORD_BITS       = 32;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_READ    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PRELOAD = 2'd2;

endpackage
`default_nettype wire

>>> rtl/core/dmwt_sram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwt_sram
// Single-port synchronous RAM with a registered read.
// A write and a read at the same address return the old contents.
// ----------------------------------------------------------------------------
module dmwt_sram #(
    parameter int DEPTH = dmwt_pkg::DEF_MEMORY_WORDS,
    parameter int WIDTH = dmwt_pkg::DEF_WORD_BITS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic              we,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/direct_mapped_write_through_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache
// Direct-mapped, write-through, no-write-allocate cache with its own backing
// memory. Request beats carry an operation (read, store, preload), a word
// address and a data word; every request yields exactly one result beat with
// the read data, the hit flag and the hit, miss and access counters.
//
// Both channels use valid/ready. A request is taken only while the control
// sequencer is idle. A read hit, a store or a preload goes from the tag lookup
// state to the result state; a read miss passes through a fill state between
// them, streaming the WORDS_PER_BLOCK words of the block one by one out of the
// single-port backing RAM into the line RAM.
// The next request can be accepted in the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and processed, and its result waits in the
// sequencer until the output register is free.
// Reset clears the line valid bits, the counters and the handshake state; the
// tag, line and backing RAMs are not cleared. Block size, line count and
// memory size must be powers of two.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache #(
    parameter int WORDS_PER_BLOCK = dmwt_pkg::DEF_WORDS_PER_BLOCK,
    parameter int LINE_COUNT      = dmwt_pkg::DEF_LINE_COUNT,
    parameter int MEMORY_WORDS    = dmwt_pkg::DEF_MEMORY_WORDS,
    parameter int WORD_BITS       = dmwt_pkg::DEF_WORD_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic        [dmwt_pkg::OP_BITS-1:0]    operation,
    input  wire logic        [dmwt_pkg::ADDR_BITS-1:0]  word_address,
    input  wire logic signed [dmwt_pkg::VALUE_BITS-1:0] write_value,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed      [dmwt_pkg::VALUE_BITS-1:0] read_value,
    output logic                                        was_hit,
    output logic             [dmwt_pkg::COUNT_BITS-1:0] hit_total,
    output logic             [dmwt_pkg::COUNT_BITS-1:0] miss_total,
    output logic             [dmwt_pkg::COUNT_BITS-1:0] access_total
);

    localparam int AW        = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam int OB        = $clog2(WORDS_PER_BLOCK);
    localparam int IB        = $clog2(LINE_COUNT);
    localparam int OFS_W     = (OB > 0) ? OB : 1;
    localparam int IDX_W     = (IB > 0) ? IB : 1;
    localparam int TAG_RAW   = AW - OB - IB;
    localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int CW        = WORDS_PER_BLOCK * LINE_COUNT;
    localparam int CW_W      = (CW > 1) ? $clog2(CW) : 1;
    localparam int CNT_W     = dmwt_pkg::COUNT_BITS;
    localparam int VAL_W     = dmwt_pkg::VALUE_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_FILL   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam logic [31:0] OFS_MASK = 32'(WORDS_PER_BLOCK - 1);
    localparam logic [31:0] IDX_MASK = 32'(LINE_COUNT - 1);
    localparam logic [OFS_W-1:0] LAST_WORD = OFS_W'(WORDS_PER_BLOCK - 1);

    logic [1:0]                    state_reg, state_next;
    logic [dmwt_pkg::OP_BITS-1:0]  op_reg;
    logic [AW-1:0]                 addr_reg;
    logic [WORD_BITS-1:0]          data_reg;
    logic [OFS_W-1:0]              fill_cnt_reg, fill_cnt_next;
    logic                          line_valid_reg [LINE_COUNT];
    logic [CNT_W-1:0]              hit_cnt_reg, miss_cnt_reg, access_cnt_reg;
    logic [VAL_W-1:0]              res_value_reg, res_value_next;
    logic                          res_hit_reg, res_hit_next;
    logic                          out_valid_reg;
    logic [VAL_W-1:0]              out_value_reg;
    logic                          out_hit_reg;
    logic [CNT_W-1:0]              out_hit_cnt_reg, out_miss_cnt_reg, out_access_cnt_reg;

    logic                          accept;
    logic                          out_load;
    logic [AW-1:0]                 in_addr;
    logic [31:0]                   in_addr_wide, q_addr_wide, fill_base_wide;
    logic [OFS_W-1:0]              in_offset, q_offset;
    logic [IDX_W-1:0]              in_index, q_index;
    logic [TAG_W-1:0]              q_tag;
    logic [CW_W-1:0]               in_line_addr, q_line_addr, fill_line_addr;
    logic                          hit;
    logic                          is_access;

    logic [AW-1:0]                 bk_addr;
    logic                          bk_we;
    logic [WORD_BITS-1:0]          bk_rdata;
    logic [CW_W-1:0]               ln_addr;
    logic                          ln_we;
    logic [WORD_BITS-1:0]          ln_wdata, ln_rdata;
    logic [IDX_W-1:0]              tg_addr;
    logic                          tg_we;
    logic [TAG_W-1:0]              tg_rdata;

    // ---- address split --------------------------------------------------
    assign in_addr      = AW'(32'(word_address));
    assign in_addr_wide = 32'(in_addr);
    assign q_addr_wide  = 32'(addr_reg);
    assign in_offset    = OFS_W'(in_addr_wide & OFS_MASK);
    assign in_index     = IDX_W'((in_addr_wide >> OB) & IDX_MASK);
    assign q_offset     = OFS_W'(q_addr_wide & OFS_MASK);
    assign q_index      = IDX_W'((q_addr_wide >> OB) & IDX_MASK);
    assign q_tag        = TAG_W'(q_addr_wide >> (OB + IB));
    assign in_line_addr = CW_W'((32'(in_index) << OB) | 32'(in_offset));
    assign q_line_addr  = CW_W'((32'(q_index) << OB) | 32'(q_offset));
    assign fill_line_addr = CW_W'((32'(q_index) << OB) | 32'(fill_cnt_reg));
    assign fill_base_wide = q_addr_wide & ~OFS_MASK;

    assign hit       = line_valid_reg[q_index] && (tg_rdata == q_tag);
    assign is_access = (op_reg == dmwt_pkg::OP_READ) || (op_reg == dmwt_pkg::OP_WRITE);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // ---- RAM port steering ----------------------------------------------
    always_comb
    begin
        bk_addr  = addr_reg;
        bk_we    = 1'b0;
        ln_addr  = q_line_addr;
        ln_we    = 1'b0;
        ln_wdata = data_reg;
        tg_addr  = q_index;
        tg_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ln_addr = in_line_addr;
                tg_addr = in_index;
            end
            ST_LOOKUP:
            begin
                if (op_reg == dmwt_pkg::OP_READ)
                begin
                    // Start streaming the block on a miss; harmless on a hit.
                    bk_addr = AW'(fill_base_wide);
                    tg_we   = !hit;
                end
                else if (op_reg == dmwt_pkg::OP_WRITE)
                begin
                    bk_we = 1'b1;
                    ln_we = hit;
                end
                else if (op_reg == dmwt_pkg::OP_PRELOAD)
                begin
                    bk_we = 1'b1;
                end
            end
            ST_FILL:
            begin
                bk_addr  = AW'(fill_base_wide + 32'(fill_cnt_reg) + 32'd1);
                ln_addr  = fill_line_addr;
                ln_we    = 1'b1;
                ln_wdata = bk_rdata;
            end
            default:
            begin
            end
        endcase
    end

    dmwt_sram #(.DEPTH(MEMORY_WORDS), .WIDTH(WORD_BITS)) u_backing (
        .clk   (clk),
        .addr  (bk_addr),
        .we    (bk_we),
        .wdata (data_reg),
        .rdata (bk_rdata)
    );

    dmwt_sram #(.DEPTH(CW), .WIDTH(WORD_BITS)) u_line_words (
        .clk   (clk),
        .addr  (ln_addr),
        .we    (ln_we),
        .wdata (ln_wdata),
        .rdata (ln_rdata)
    );

    dmwt_sram #(.DEPTH(LINE_COUNT), .WIDTH(TAG_W)) u_line_tags (
        .clk   (clk),
        .addr  (tg_addr),
        .we    (tg_we),
        .wdata (q_tag),
        .rdata (tg_rdata)
    );

    // ---- sequencer --------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        fill_cnt_next  = fill_cnt_reg;
        res_value_next = res_value_reg;
        res_hit_next   = res_hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                res_value_next = '0;
                res_hit_next   = is_access && hit;
                state_next     = ST_DONE;
                if (op_reg == dmwt_pkg::OP_READ)
                begin
                    if (hit)
                    begin
                        res_value_next = VAL_W'(64'(ln_rdata));
                    end
                    else
                    begin
                        fill_cnt_next = '0;
                        state_next    = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if (fill_cnt_reg == q_offset)
                begin
                    res_value_next = VAL_W'(64'(bk_rdata));
                end
                if (fill_cnt_reg == LAST_WORD)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + OFS_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            access_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                line_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOOKUP && is_access)
            begin
                access_cnt_reg <= access_cnt_reg + CNT_W'(1);
                if (hit)
                begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
            end
            if (state_reg == ST_LOOKUP && op_reg == dmwt_pkg::OP_READ && !hit)
            begin
                line_valid_reg[q_index] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            addr_reg <= in_addr;
            data_reg <= WORD_BITS'(64'($unsigned(write_value)));
        end
        fill_cnt_reg  <= fill_cnt_next;
        res_value_reg <= res_value_next;
        res_hit_reg   <= res_hit_next;
        if (out_load)
        begin
            out_value_reg      <= res_value_reg;
            out_hit_reg        <= res_hit_reg;
            out_hit_cnt_reg    <= hit_cnt_reg;
            out_miss_cnt_reg   <= miss_cnt_reg;
            out_access_cnt_reg <= access_cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = $signed(out_value_reg);
    assign was_hit      = out_hit_reg;
    assign hit_total    = out_hit_cnt_reg;
    assign miss_total   = out_miss_cnt_reg;
    assign access_total = out_access_cnt_reg;

    // ---- assertions -------------------------------------------------------
    // Every access counts as exactly one hit or one miss.
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        access_cnt_reg == hit_cnt_reg + miss_cnt_reg)
        else $error("access counter differs from hits plus misses");

    a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && op_reg == dmwt_pkg::OP_READ && !hit)
        |=> (state_reg == ST_FILL && fill_cnt_reg == '0))
        else $error("read miss did not start a block fill");

    a_filled_line_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && fill_cnt_reg == LAST_WORD)
        |=> (state_reg == ST_DONE && line_valid_reg[q_index]))
        else $error("filled line not marked valid");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready)
        |=> (state_reg == ST_DONE && $stable(out_value_reg)))
        else $error("result moved while output register was full");

endmodule
`default_nettype wire

>>> verif/direct_mapped_write_through_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache_tb
// Self-checking bench for the direct-mapped write-through cache. A local
// scoreboard mirrors the line valid bits, tags, line words, backing memory
// and counters. It predicts every result beat from the request beats as they
// are accepted, and each result beat is compared field by field. Directed
// edge cases come first, then random traffic that stays mostly inside a
// moving hot window so that hits, evictions and write hits happen often.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache_tb;

    localparam int WPB          = dmwt_pkg::DEF_WORDS_PER_BLOCK;
    localparam int LINES        = dmwt_pkg::DEF_LINE_COUNT;
    localparam int MEM_WORDS    = dmwt_pkg::DEF_MEMORY_WORDS;
    localparam int BLOCKS       = MEM_WORDS / WPB;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOT_SPAN     = 24;
    localparam int OPW          = dmwt_pkg::OP_BITS;
    localparam int AW           = dmwt_pkg::ADDR_BITS;
    localparam int VW           = dmwt_pkg::VALUE_BITS;
    localparam int CW           = dmwt_pkg::COUNT_BITS;

    // The package defines no name for the fourth operation code.
    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [VW-1:0] rdata;
        logic          hit;
        logic [CW-1:0] hits;
        logic [CW-1:0] misses;
        logic [CW-1:0] accesses;
    } cache_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OPW-1:0]       operation = dmwt_pkg::OP_READ;
    logic [AW-1:0]        word_address = '0;
    logic signed [VW-1:0] write_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [VW-1:0] read_value;
    logic                 was_hit;
    logic [CW-1:0]        hit_total;
    logic [CW-1:0]        miss_total;
    logic [CW-1:0]        access_total;

    // Scoreboard copy of the cache.
    bit              line_ok   [LINES];
    int unsigned     line_tags [LINES];
    bit [VW-1:0]     line_data [LINES*WPB];
    bit [VW-1:0]     mem_image [MEM_WORDS];
    bit              mem_loaded[MEM_WORDS];
    bit [CW-1:0]     hit_count;
    bit [CW-1:0]     miss_count;
    bit [CW-1:0]     access_count;

    cache_result_t pending_results[$];
    int unsigned   items_sent;
    int unsigned   mismatches;
    bit            sender_eager;

    direct_mapped_write_through_cache u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .word_address (word_address),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .was_hit      (was_hit),
        .hit_total    (hit_total),
        .miss_total   (miss_total),
        .access_total (access_total)
    );

    always #4 clk = ~clk;

    function automatic cache_result_t predict_cache_access(logic [OPW-1:0] op,
                                                           logic [AW-1:0] addr,
                                                           logic [VW-1:0] data);
        int unsigned   offset;
        int unsigned   blk;
        int unsigned   idx;
        int unsigned   tag;
        int unsigned   base;
        bit            hit;
        cache_result_t res;
        offset = addr % WPB;
        blk    = addr / WPB;
        idx    = blk % LINES;
        tag    = addr / (WPB * LINES);
        base   = idx * WPB;
        hit    = line_ok[idx] && line_tags[idx] == tag;
        res    = '0;
        case (op)
            dmwt_pkg::OP_READ:
            begin
                access_count++;
                if (hit)
                begin
                    hit_count++;
                end
                else
                begin
                    miss_count++;
                    line_ok[idx]   = 1'b1;
                    line_tags[idx] = tag;
                    for (int i = 0; i < WPB; i++)
                    begin
                        line_data[base + i] = mem_image[(blk * WPB + i) % MEM_WORDS];
                    end
                end
                res.rdata = line_data[base + offset];
                res.hit   = hit;
            end
            dmwt_pkg::OP_WRITE:
            begin
                access_count++;
                mem_image[addr] = data;
                if (hit)
                begin
                    hit_count++;
                    line_data[base + offset] = data;
                end
                else
                begin
                    miss_count++;
                end
                res.hit = hit;
            end
            dmwt_pkg::OP_PRELOAD:
            begin
                mem_image[addr] = data;
            end
            default:
            begin
            end
        endcase
        res.hits     = hit_count;
        res.misses   = miss_count;
        res.accesses = access_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_request(logic [OPW-1:0] op, int unsigned addr,
                                logic [VW-1:0] data);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        word_address <= AW'(addr);
        write_value  <= data;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_cache_access(op, AW'(addr), data));
        if (op == dmwt_pkg::OP_WRITE || op == dmwt_pkg::OP_PRELOAD)
        begin
            mem_loaded[addr] = 1'b1;
        end
        items_sent++;
    endtask

    // A read miss fetches the whole block, so every word of it must hold data.
    task automatic make_block_readable(int unsigned addr);
        int unsigned first;
        first = addr - addr % WPB;
        for (int unsigned w = first; w < first + WPB; w++)
        begin
            if (!mem_loaded[w])
            begin
                send_request(dmwt_pkg::OP_PRELOAD, w, $urandom);
            end
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_field_extremes();
        send_request(dmwt_pkg::OP_PRELOAD, 0, 32'h8000_0000);
        send_request(dmwt_pkg::OP_PRELOAD, 1, 32'h7FFF_FFFF);
        send_request(dmwt_pkg::OP_PRELOAD, 2, 32'h0000_0000);
        send_request(dmwt_pkg::OP_PRELOAD, 3, 32'hFFFF_FFFF);
        send_request(dmwt_pkg::OP_PRELOAD, MEM_WORDS - 4, 32'h5A5A_A5A5);
        send_request(dmwt_pkg::OP_PRELOAD, MEM_WORDS - 3, 32'hFFFF_FFFF);
        send_request(dmwt_pkg::OP_PRELOAD, MEM_WORDS - 2, 32'h8000_0001);
        send_request(dmwt_pkg::OP_PRELOAD, MEM_WORDS - 1, 32'h7FFF_FFFE);
        send_request(dmwt_pkg::OP_READ, 0, 32'hFFFF_FFFF);
        send_request(dmwt_pkg::OP_READ, 3, 32'h0);
        send_request(dmwt_pkg::OP_READ, MEM_WORDS - 1, 32'h0);
        send_request(dmwt_pkg::OP_READ, MEM_WORDS - 4, 32'h0);
    endtask

    task automatic test_each_operation();
        send_request(dmwt_pkg::OP_WRITE, 2, 32'hAAAA_5555);
        send_request(dmwt_pkg::OP_READ, 2, 32'h0);
        // Same line index, other tag: a store miss must not allocate.
        send_request(dmwt_pkg::OP_WRITE, WPB * LINES, 32'h1234_5678);
        send_request(dmwt_pkg::OP_PRELOAD, WPB * LINES + 1, 32'h0BAD_F00D);
        send_request(dmwt_pkg::OP_PRELOAD, WPB * LINES + 2, 32'hDEAD_BEEF);
        send_request(dmwt_pkg::OP_PRELOAD, WPB * LINES + 3, 32'hC001_D00D);
        send_request(dmwt_pkg::OP_READ, WPB * LINES, 32'h0);
        send_request(dmwt_pkg::OP_READ, 0, 32'h0);
        send_request(OP_UNUSED, 5, 32'hFFFF_FFFF);
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        send_request(dmwt_pkg::OP_READ, 1, 32'h0);
        send_request(dmwt_pkg::OP_WRITE, 1, 32'h0F0F_F0F0);
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned round;
        int unsigned hot_block;
        int unsigned addr;
        int unsigned op_draw;
        logic [OPW-1:0] op;
        logic [VW-1:0]  data;
        start = items_sent;
        round = 0;
        hot_block = $urandom_range(0, BLOCKS - 1);
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (round % 150 == 0)
            begin
                hot_block    = $urandom_range(0, BLOCKS - 1);
                sender_eager = ($urandom_range(0, 3) == 0);
            end
            if (round == RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
            end
            if ($urandom_range(0, 3) != 0)
            begin
                addr = ((hot_block + $urandom_range(0, HOT_SPAN - 1)) % BLOCKS) * WPB
                       + $urandom_range(0, WPB - 1);
            end
            else
            begin
                addr = $urandom_range(0, MEM_WORDS - 1);
            end
            op_draw = $urandom_range(0, 19);
            if (op_draw < 10)
            begin
                op = dmwt_pkg::OP_READ;
            end
            else if (op_draw < 16)
            begin
                op = dmwt_pkg::OP_WRITE;
            end
            else if (op_draw < 19)
            begin
                op = dmwt_pkg::OP_PRELOAD;
            end
            else
            begin
                op = OP_UNUSED;
            end
            case ($urandom_range(0, 15))
                0:       data = 32'h8000_0000;
                1:       data = 32'h7FFF_FFFF;
                2:       data = 32'hFFFF_FFFF;
                3:       data = 32'h0000_0000;
                default: data = $urandom;
            endcase
            if (op == dmwt_pkg::OP_READ)
            begin
                make_block_readable(addr);
            end
            send_request(op, addr, data);
            round++;
        end
        sender_eager = 1'b0;
    endtask

    // Result side: stalls a random number of cycles before each beat.
    initial
    begin : result_sink
        int stall;
        int unsigned served;
        bit calm;
        served = 0;
        calm   = 1'b0;
        @(posedge clk);
        forever
        begin
            if (served % 48 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            served++;
        end
    end

    always @(posedge clk)
    begin : result_check
        cache_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat, read_value", read_value, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("read_value", read_value, want.rdata);
                compare_field("was_hit", 32'(was_hit), 32'(want.hit));
                compare_field("hit_total", hit_total, want.hits);
                compare_field("miss_total", miss_total, want.misses);
                compare_field("access_total", access_total, want.accesses);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        items_sent   = 0;
        mismatches   = 0;
        sender_eager = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_each_operation();
        test_drain_pause();
        test_random_traffic();
        wait_for_drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
